// ===== hdl/layer_norm_forward_core_defines.svh =====
// ---------------------------------------------------------------------------
// Layer norm forward core: assertion macros
// Shared property templates for the core's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef LAYER_NORM_FORWARD_CORE_DEFINES_SVH
`define LAYER_NORM_FORWARD_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LNF_ASSERT_NOW(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("lnf check failed");

// next-cycle implication, disabled in reset
`define LNF_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("lnf check failed");

`endif

// ===== hdl/lnf_pkg.sv =====
// ---------------------------------------------------------------------------
// lnf_pkg
// Types and constants shared by the layer norm forward core.
// ---------------------------------------------------------------------------
package lnf_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W      = $clog2(MAX_ELEMENTS);
    localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1);
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + ADDR_W;
    localparam int T_W         = SUM_W + 2;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_W + 1;
    localparam int ACC_W       = SQ_W + ADDR_W;
    localparam int GD_W        = SAMPLE_W + DIFF_W;
    localparam int SD_W        = 24;
    localparam int DEN_W       = SD_W + 1;
    localparam int DIV_NUM_W   = (ACC_W > GD_W + 6) ? ACC_W : GD_W + 6;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
    localparam int VAR_W       = SQ_W;
    localparam int SQRT_VAL_W  = 2 * (SD_W + 1);
    localparam int ROOT_W      = SD_W + 1;
    localparam int SQRT_REM_W  = ROOT_W + 1;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd2;

    localparam logic signed [15:0] GAIN_RESET    = 16'sd3686;
    localparam logic signed [15:0] OFFSET_RESET  = 16'sd0;
    localparam logic [15:0]        EPSILON_RESET = 16'd1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] result;
        logic               saturated;
        logic               last_out;
    } out_item_t;

    typedef enum logic [1:0] {
        DIV_NONE = 2'd0,
        DIV_MEAN = 2'd1,
        DIV_VAR  = 2'd2,
        DIV_Q    = 2'd3
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    clear_set;
        div_op_t div_op;
        logic    mean_cap;
        logic    acc_clear;
        logic    acc_add;
        logic    idx_clear;
        logic    idx_inc;
        logic    sqrt_start;
        logic    out_load;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic last_elem;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/lnf_ram.sv =====
// ---------------------------------------------------------------------------
// lnf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lnf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lnf_ctrl.sv =====
// ---------------------------------------------------------------------------
// lnf_ctrl
// Sequencer: load, mean, variance pass, square root, per-element emit.
// ---------------------------------------------------------------------------
module lnf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last,
    output logic          s_ready,
    input  lnf_pkg::sts_t sts,
    output lnf_pkg::cmd_t cmd
);

    typedef enum logic [15:0] {
        ST_LOAD       = 16'h0001,
        ST_MEAN_START = 16'h0002,
        ST_MEAN_WAIT  = 16'h0004,
        ST_V_RD       = 16'h0008,
        ST_V_SUB      = 16'h0010,
        ST_V_MUL      = 16'h0020,
        ST_V_ACC      = 16'h0040,
        ST_VAR_START  = 16'h0080,
        ST_VAR_WAIT   = 16'h0100,
        ST_SQRT_WAIT  = 16'h0200,
        ST_E_RD       = 16'h0400,
        ST_E_SUB      = 16'h0800,
        ST_E_MUL      = 16'h1000,
        ST_E_DIV      = 16'h2000,
        ST_E_WAIT     = 16'h4000,
        ST_E_OUT      = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = lnf_pkg::DIV_NONE;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (sts.full) begin
                        state_next = ST_MEAN_START;
                    end else begin
                        cmd.load = 1'b1;
                        if (s_last) begin
                            state_next = ST_MEAN_START;
                        end
                    end
                end
            end
            ST_MEAN_START: begin
                cmd.div_op    = lnf_pkg::DIV_MEAN;
                cmd.idx_clear = 1'b1;
                cmd.acc_clear = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.mean_cap = 1'b1;
                    state_next   = ST_V_RD;
                end
            end
            ST_V_RD:  state_next = ST_V_SUB;
            ST_V_SUB: state_next = ST_V_MUL;
            ST_V_MUL: state_next = ST_V_ACC;
            ST_V_ACC: begin
                cmd.acc_add = 1'b1;
                if (sts.last_elem) begin
                    state_next = ST_VAR_START;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_V_RD;
                end
            end
            ST_VAR_START: begin
                cmd.div_op = lnf_pkg::DIV_VAR;
                state_next = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT: begin
                if (!sts.sqrt_busy) begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_E_RD;
                end
            end
            ST_E_RD:  state_next = ST_E_SUB;
            ST_E_SUB: state_next = ST_E_MUL;
            ST_E_MUL: state_next = ST_E_DIV;
            ST_E_DIV: begin
                cmd.div_op = lnf_pkg::DIV_Q;
                state_next = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_E_OUT;
                end
            end
            ST_E_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = sts.last_elem;
                    if (sts.last_elem) begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_E_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/lnf_dp.sv =====
// ---------------------------------------------------------------------------
// lnf_dp
// Datapath: sample store, sums, shared serial divider, serial square root,
// configuration registers and output register.
// ---------------------------------------------------------------------------
module lnf_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lnf_pkg::cmd_t                       cmd,
    output lnf_pkg::sts_t                       sts,
    input  lnf_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lnf_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    input  logic [lnf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int AW  = lnf_pkg::ADDR_W;
    localparam int CW  = lnf_pkg::CNT_W;
    localparam int NW  = lnf_pkg::DIV_NUM_W;
    localparam int DW  = lnf_pkg::DEN_W;
    localparam int TW  = lnf_pkg::T_W;
    localparam int RW  = NW + 2;

    // configuration
    logic signed [15:0] gain_reg, offset_reg;
    logic [15:0]        eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= lnf_pkg::GAIN_RESET;
            offset_reg <= lnf_pkg::OFFSET_RESET;
            eps_reg    <= lnf_pkg::EPSILON_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lnf_pkg::CFG_GAIN:    gain_reg   <= cfg_data;
                lnf_pkg::CFG_OFFSET:  offset_reg <= cfg_data;
                lnf_pkg::CFG_EPSILON: eps_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // store and set counters
    logic [CW-1:0]                    count_reg;
    logic signed [lnf_pkg::SUM_W-1:0] sum_reg;
    logic [AW-1:0]                    idx_reg;
    logic [15:0]                      rdata;

    lnf_ram #(.WIDTH(16), .DEPTH(lnf_pkg::MAX_ELEMENTS)) u_store (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_data.sample),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.clear_set) begin
                count_reg <= '0;
                sum_reg   <= '0;
            end else if (cmd.load) begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + lnf_pkg::SUM_W'(s_data.sample);
            end
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    assign sts.full      = (count_reg == CW'(lnf_pkg::MAX_ELEMENTS));
    assign sts.last_elem = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // rounding numerator for the mean
    logic signed [TW-1:0] t_val;
    logic                 t_neg;
    logic [TW-1:0]        t_mag;

    assign t_val = (TW'(sum_reg) <<< 1) + $signed(TW'(count_reg));
    assign t_neg = t_val[TW-1];
    assign t_mag = t_neg ? TW'(-t_val) : TW'(t_val);

    // difference and products
    logic signed [15:0]                mean_reg;
    logic signed [lnf_pkg::DIFF_W-1:0] d_reg;
    logic [lnf_pkg::SQ_W-1:0]          sq_reg;
    logic signed [lnf_pkg::GD_W-1:0]   gd_reg;
    logic [lnf_pkg::ACC_W-1:0]         acc_reg;
    logic signed [2*lnf_pkg::DIFF_W-1:0] sq_full;

    assign sq_full = d_reg * d_reg;

    always_ff @(posedge aclk) begin
        d_reg  <= lnf_pkg::DIFF_W'($signed(rdata)) - lnf_pkg::DIFF_W'(mean_reg);
        sq_reg <= sq_full[lnf_pkg::SQ_W-1:0];
        gd_reg <= gain_reg * d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + lnf_pkg::ACC_W'(sq_reg);
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [NW-1:0]                  quot_reg;
    logic [DW-1:0]                  rem_reg, den_reg;
    logic [lnf_pkg::DIV_CNT_W-1:0]  dcnt_reg;
    logic [DW:0]                    rem_sh;
    logic                           rem_ge;
    logic [lnf_pkg::SD_W-1:0]       sd;
    logic                           gd_neg;
    logic [lnf_pkg::GD_W-1:0]       gd_mag;

    assign rem_sh = {rem_reg, quot_reg[NW-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});
    assign gd_neg = gd_reg[lnf_pkg::GD_W-1];
    assign gd_mag = gd_neg ? lnf_pkg::GD_W'(-gd_reg) : lnf_pkg::GD_W'(gd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_op != lnf_pkg::DIV_NONE) begin
            dcnt_reg <= lnf_pkg::DIV_CNT_W'(NW);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - lnf_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.div_op)
            lnf_pkg::DIV_MEAN: begin
                quot_reg <= NW'(t_mag);
                den_reg  <= DW'({count_reg, 1'b0});
                rem_reg  <= '0;
            end
            lnf_pkg::DIV_VAR: begin
                quot_reg <= NW'(acc_reg);
                den_reg  <= DW'(count_reg);
                rem_reg  <= '0;
            end
            lnf_pkg::DIV_Q: begin
                quot_reg <= (NW'(gd_mag) << 5) + NW'(sd);
                den_reg  <= {sd, 1'b0};
                rem_reg  <= '0;
            end
            default: begin
                if (dcnt_reg != '0) begin
                    quot_reg <= {quot_reg[NW-2:0], rem_ge};
                    rem_reg  <= rem_ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
                end
            end
        endcase
    end

    assign sts.div_busy = (dcnt_reg != '0);

    // rounded mean, floor of the doubled form
    logic [TW-1:0] mean_mag;

    assign mean_mag = TW'(quot_reg) + TW'(t_neg && (rem_reg != '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= '0;
        end else if (cmd.mean_cap) begin
            mean_reg <= t_neg ? 16'(-mean_mag) : 16'(mean_mag);
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    logic [lnf_pkg::SQRT_VAL_W-1:0]  sval_reg;
    logic [lnf_pkg::SQRT_REM_W-1:0]  srem_reg;
    logic [lnf_pkg::ROOT_W-1:0]      root_reg;
    logic [lnf_pkg::SQRT_CNT_W-1:0]  scnt_reg;
    logic [lnf_pkg::SQRT_REM_W+1:0]  srem_sh, strial;
    logic                            s_ge;
    logic [lnf_pkg::VAR_W:0]         var_eps;

    assign var_eps = (lnf_pkg::VAR_W + 1)'(quot_reg[lnf_pkg::VAR_W-1:0])
                   + (lnf_pkg::VAR_W + 1)'(eps_reg);
    assign srem_sh = {srem_reg, sval_reg[lnf_pkg::SQRT_VAL_W-1 -: 2]};
    assign strial  = (lnf_pkg::SQRT_REM_W + 2)'({root_reg, 2'b01});
    assign s_ge    = (srem_sh >= strial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scnt_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_start) begin
            scnt_reg <= lnf_pkg::SQRT_CNT_W'(lnf_pkg::ROOT_W);
            root_reg <= '0;
        end else if (scnt_reg != '0) begin
            scnt_reg <= scnt_reg - lnf_pkg::SQRT_CNT_W'(1);
            root_reg <= {root_reg[lnf_pkg::ROOT_W-2:0], s_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            sval_reg <= lnf_pkg::SQRT_VAL_W'({var_eps, 16'b0});
            srem_reg <= '0;
        end else if (scnt_reg != '0) begin
            sval_reg <= sval_reg << 2;
            srem_reg <= s_ge ? lnf_pkg::SQRT_REM_W'(srem_sh - strial)
                             : lnf_pkg::SQRT_REM_W'(srem_sh);
        end
    end

    assign sd            = root_reg[lnf_pkg::SD_W-1:0];
    assign sts.sqrt_busy = (scnt_reg != '0);

    // scale, shift and clip
    logic signed [RW-1:0] q_val, r_val;
    logic                 r_hi, r_lo;

    assign q_val = (sd == '0) ? '0
                 : (gd_neg ? -$signed({2'b00, quot_reg}) : $signed({2'b00, quot_reg}));
    assign r_val = q_val + RW'(offset_reg);
    assign r_hi  = (r_val > RW'(32767));
    assign r_lo  = (r_val < -RW'(32768));

    logic      out_valid_reg;
    lnf_pkg::out_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.result    <= r_hi ? 16'sh7fff : (r_lo ? 16'sh8000 : r_val[15:0]);
            out_reg.saturated <= r_hi || r_lo;
            out_reg.last_out  <= cmd.out_last;
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;

endmodule

// ===== hdl/layer_norm_forward_core.sv =====
// ---------------------------------------------------------------------------
// layer_norm_forward_core
// Loading takes one sample per cycle while s_ready is high. After the set
// ends: the mean divide, the variance pass, the variance divide, the square
// root, then one divide per result, each divide on the serial
// one-bit-per-cycle divider (NW = 39 quotient bits at 64 entries).
// Reset (aresetn low, synchronous) empties the set, clears the output beat
// and restores gain 3686, offset 0, epsilon 1. Config writes are always ready.
// ---------------------------------------------------------------------------
`include "layer_norm_forward_core_defines.svh"

module layer_norm_forward_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lnf_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lnf_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);

    lnf_pkg::cmd_t cmd;
    lnf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    lnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_in),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lnf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    `LNF_ASSERT_NOW(a_no_load_while_div, aclk, aresetn, sts.div_busy, !s_ready)
    `LNF_ASSERT_NOW(a_out_slot_free, aclk, aresetn, cmd.out_load, sts.out_free)
    `LNF_ASSERT_NEXT(a_full_ends_set, aclk, aresetn, s_valid && s_ready && sts.full, !s_ready)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer norm forward core testbench
// Drives sample sets through the input channel under random idling and
// back-pressure, writes the gain, offset and epsilon registers between
// sets, and compares every output beat with a bit-exact predictor kept
// in a small scoreboard class.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 3000;

    class norm_scoreboard;
        logic signed [15:0] gain;
        logic signed [15:0] offset;
        logic [15:0]        epsilon;
        logic signed [15:0] store [lnf_pkg::MAX_ELEMENTS];
        int                 count;
        longint             sum;
        lnf_pkg::out_item_t pending [$];
        int                 errors;

        function new();
            gain    = lnf_pkg::GAIN_RESET;
            offset  = lnf_pkg::OFFSET_RESET;
            epsilon = lnf_pkg::EPSILON_RESET;
            count   = 0;
            sum     = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [lnf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                lnf_pkg::CFG_GAIN:    gain    = val;
                lnf_pkg::CFG_OFFSET:  offset  = val;
                lnf_pkg::CFG_EPSILON: epsilon = val;
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void emit_set();
            longint             t, den, mean, d, num, q, r;
            longint unsigned    sq, var_q, sd, mag, qm;
            lnf_pkg::out_item_t o;
            den = 2 * count;
            t   = 2 * sum + count;
            if (t >= 0) mean = t / den;
            else mean = -((-t + den - 1) / den);
            sq = 0;
            for (int i = 0; i < count; i++) begin
                d  = longint'(store[i]) - mean;
                sq = sq + longint'(d * d);
            end
            var_q = sq / count;
            sd    = int_sqrt((var_q + epsilon) << 16) & 64'hFFFFFF;
            for (int i = 0; i < count; i++) begin
                d   = longint'(store[i]) - mean;
                num = longint'(gain) * d * 16;
                q   = 0;
                if (sd != 0) begin
                    mag = (num < 0) ? -num : num;
                    qm  = (2 * mag + sd) / (2 * sd);
                    q   = (num < 0) ? -longint'(qm) : longint'(qm);
                end
                r = q + longint'(offset);
                o.saturated = 1'b0;
                if (r > 32767) begin
                    r = 32767;
                    o.saturated = 1'b1;
                end
                if (r < -32768) begin
                    r = -32768;
                    o.saturated = 1'b1;
                end
                o.result   = r[15:0];
                o.last_out = (i + 1 == count);
                pending.push_back(o);
            end
            count = 0;
            sum   = 0;
        endfunction

        function void note_input(lnf_pkg::in_item_t it);
            if (count >= lnf_pkg::MAX_ELEMENTS) begin
                emit_set();
                return;
            end
            store[count] = it.sample;
            sum   = sum + longint'(it.sample);
            count = count + 1;
            if (it.last_in) emit_set();
        endfunction

        function void check_result(lnf_pkg::out_item_t got);
            lnf_pkg::out_item_t want;
            if (pending.size() == 0) begin
                $error("unexpected output beat result=%0d", got.result);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %0d, actual %0d", want.result, got.result);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    lnf_pkg::in_item_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    lnf_pkg::out_item_t            m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lnf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;

    norm_scoreboard sb = new();
    bit             hold_req = 0;
    bit             quiet    = 0;
    int             cycles   = 0;

    layer_norm_forward_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: check beats at rising edge, change ready at falling edge
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                m_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall   = $urandom_range(1, 14) - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_beat(logic signed [15:0] x, logic last);
        lnf_pkg::in_item_t it;
        it.sample  = x;
        it.last_in = last;
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        @(negedge aclk);
        s_valid = 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 14)) @(negedge aclk);
    endtask

    task automatic drain();
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (60) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(logic [lnf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_value(bit is_signed);
        case ($urandom_range(0, 5))
            0: return is_signed ? 16'h7FFF : 16'hFFFF;
            1: return is_signed ? 16'h8000 : 16'h0000;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample(int mode, logic signed [15:0] base);
        case (mode)
            0: return 16'($urandom);
            1: return base + $signed(16'($urandom_range(0, 15)) - 16'd8);
            2: return base;
            default: return ($urandom_range(0, 7) == 0) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    initial begin
        int               len, mode, sent;
        logic signed [15:0] base;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = lnf_pkg::CFG_GAIN;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (5) @(negedge aclk);

        // directed: default registers
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        send_beat(16'sd300, 1'b1);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd1, 1'b0);
        send_beat(-16'sd1, 1'b1);

        // zero deviation with epsilon cleared, extreme offset
        write_cfg(lnf_pkg::CFG_EPSILON, 16'h0000);
        write_cfg(lnf_pkg::CFG_OFFSET, 16'h7FFF);
        send_beat(16'sd77, 1'b0);
        send_beat(16'sd77, 1'b0);
        send_beat(16'sd77, 1'b1);

        // large gain with an outlier, then negative gain and offset drive saturation low
        write_cfg(lnf_pkg::CFG_GAIN, 16'h7FFF);
        write_cfg(lnf_pkg::CFG_OFFSET, 16'h0000);
        for (int i = 0; i < 7; i++) send_beat(16'sd0, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        write_cfg(lnf_pkg::CFG_GAIN, 16'h8000);
        write_cfg(lnf_pkg::CFG_EPSILON, 16'hFFFF);
        write_cfg(lnf_pkg::CFG_OFFSET, 16'h8000);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sd5, 1'b0);
        send_beat(16'sh7FFF, 1'b1);

        // back-pressure: full store, arriving beat closes the set and is dropped
        write_cfg(lnf_pkg::CFG_GAIN, lnf_pkg::GAIN_RESET);
        write_cfg(lnf_pkg::CFG_OFFSET, 16'd256);
        write_cfg(lnf_pkg::CFG_EPSILON, lnf_pkg::EPSILON_RESET);
        hold_req = 1;
        for (int i = 0; i < lnf_pkg::MAX_ELEMENTS; i++) send_beat(16'($urandom), 1'b0);
        send_beat(16'sd123, 1'b1);
        for (int i = 0; i < 4; i++) send_beat(16'($urandom), i == 3);

        // random sets
        sent = 0;
        while (sent < 65) begin
            if ($urandom_range(0, 3) == 0)
                write_cfg(lnf_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                          pick_value($urandom_range(0, 2) != 2));
            if (sent > 40) quiet = 1;
            if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 30);
            else len = $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            base = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0) send_beat(pick_sample(0, base), 1'b1);
                else send_beat(pick_sample(mode, base), i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) drain();
        end

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
